### rtl/assert_macros.svh
// Assertion shorthands for the block's concurrent checks.
// Each check runs on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mexp_pkg.sv
package mexp_pkg;

  // Default operand width.
  localparam int DEF_WIDTH = 32;

  // Register indexes of the configuration port.
  localparam int REG_MODULUS = 0;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_BIT    = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_SQR    = 6'b010000,
    ST_FIN    = 6'b100000
  } mexp_state_t;

endpackage

### rtl/modular_exponentiation.sv
// Modular exponentiation, right to left square and multiply.
// Input channel (in_valid/in_ready) carries one beat of base and exponent; the
// result channel (out_valid/out_ready) returns one beat of base**exponent mod n.
// The modulus n is written over the APB-style cfg_ port at byte address 0 and
// should be changed only while the block is idle.
// One item at a time: in_ready is high only when no item is at work. All
// arithmetic runs through a single modular double-and-add unit, one multiplier
// bit per cycle. The base is reduced first; then each exponent bit up to the
// highest set one costs a squaring, preceded by a multiplication when the bit
// is set. A zero exponent skips the squarings and multiplications, and a zero
// modulus skips all arithmetic and goes straight to the final state.
// The result sits in an output register, so a new item may be taken one cycle
// after it is loaded, while it waits; a stalled receiver holds the next result
// back in its final state until the register is free. Synchronous reset sets
// the modulus to 1, drops out_valid and returns to idle.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [WIDTH-1:0]                    in_base,
  input  logic [WIDTH-1:0]                    in_exponent,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [WIDTH-1:0]                    out_power_result,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [((WIDTH > 32) ? 3 : 2):0]     cfg_paddr,
  input  logic [((WIDTH > 32) ? 64 : 32)-1:0] cfg_pwdata,
  output logic [((WIDTH > 32) ? 64 : 32)-1:0] cfg_prdata,
  output logic                                cfg_pready
);

  localparam int DW  = (WIDTH > 32) ? 64 : 32;
  localparam int AS  = (WIDTH > 32) ? 3 : 2;
  localparam int CW  = $clog2(WIDTH);
  localparam int TW  = WIDTH + 2;
  localparam logic [CW-1:0]    LAST = CW'(WIDTH - 1);
  localparam logic [WIDTH-1:0] ONE  = {{(WIDTH-1){1'b0}}, 1'b1};

  mexp_state_t      state_r, state_nxt;
  logic [WIDTH-1:0] n_r;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] mplier_r, mplier_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             reg_hit;
  logic             cfg_wr;
  logic [WIDTH-1:0] x_sel;
  logic [WIDTH-1:0] addend;
  logic [TW-1:0]    t_sum, n1, n2, t_red;
  logic [WIDTH-1:0] step_res;
  logic             last;

  // Configuration port.
  assign reg_hit    = (cfg_paddr[AS] == 1'(REG_MODULUS));
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = '0;
    if (reg_hit) begin
      cfg_prdata = DW'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= ONE;
    end else if (cfg_wr && reg_hit) begin
      n_r <= cfg_pwdata[WIDTH-1:0];
    end
  end

  // Shared unit: r <- (2r + bit * x) mod n. Since r < n and x < n the sum stays
  // below 3n, so one subtraction of n or of 2n brings it back into range.
  always_comb begin
    unique case (state_r)
      ST_REDUCE: x_sel = ONE;
      ST_SQR:    x_sel = b_r;
      default:   x_sel = acc_r;
    endcase
    addend = mplier_r[WIDTH-1] ? x_sel : '0;
    t_sum  = {1'b0, r_r, 1'b0} + {2'b00, addend};
    n1     = {2'b00, n_r};
    n2     = {1'b0, n_r, 1'b0};
    if (t_sum >= n2) begin
      t_red = t_sum - n2;
    end else if (t_sum >= n1) begin
      t_red = t_sum - n1;
    end else begin
      t_red = t_sum;
    end
    step_res = t_red[WIDTH-1:0];
  end

  assign last = (cnt_r == LAST);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    b_nxt         = b_r;
    e_nxt         = e_r;
    r_nxt         = r_r;
    mplier_nxt    = mplier_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          e_nxt      = in_exponent;
          mplier_nxt = in_base;
          r_nxt      = '0;
          cnt_nxt    = '0;
          acc_nxt    = (n_r == ONE) ? '0 : ONE;
          if (n_r == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        r_nxt      = step_res;
        mplier_nxt = {mplier_r[WIDTH-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
        if (last) begin
          r_nxt   = '0;
          cnt_nxt = '0;
          if (state_r == ST_MUL) begin
            acc_nxt    = step_res;
            mplier_nxt = b_r;
            state_nxt  = ST_SQR;
          end else begin
            // Reduction and squaring both leave the new base.
            b_nxt     = step_res;
            state_nxt = ST_BIT;
            if (state_r == ST_SQR) begin
              e_nxt = {1'b0, e_r[WIDTH-1:1]};
            end
          end
        end
      end
      ST_BIT: begin
        r_nxt      = '0;
        cnt_nxt    = '0;
        mplier_nxt = b_r;
        if (e_r == '0) begin
          state_nxt = ST_FIN;
        end else if (e_r[0]) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SQR;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    b_r        <= b_nxt;
    e_r        <= e_nxt;
    r_r        <= r_nxt;
    mplier_r   <= mplier_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready,
               state_r != ST_IDLE, "accepted beat left block idle")
  `ASSERT_NEXT(a_fin_holds_on_stall, (state_r == ST_FIN) && out_valid_r && !out_ready,
               (state_r == ST_FIN) && out_valid_r, "result overwritten while receiver stalls")
  `ASSERT_SAME(a_mul_on_set_bit, state_r == ST_MUL,
               e_r[0], "multiply step on a clear exponent bit")
  `ASSERT_NEXT(a_bit_done_to_fin, (state_r == ST_BIT) && (e_r == '0),
               state_r == ST_FIN, "exponent exhausted but work goes on")

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  localparam int W = DEF_WIDTH;
  localparam int AW = (W > 32) ? 4 : 3;
  localparam int DW = (W > 32) ? 64 : 32;
  localparam int REG_STRIDE = (W > 32) ? 8 : 4;
  // Index past the last register; writes there must not land anywhere.
  localparam int REG_UNUSED = REG_MODULUS + 1;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 36;

  class PowerScoreboard;
    logic [W-1:0] modulus;
    logic [W-1:0] expected_q[$];
    int unsigned errors;

    function new();
      modulus = 1;
      errors = 0;
    endfunction

    // Right-to-left square and multiply; operands stay below 2**W, so the
    // double-width products are exact.
    function logic [W-1:0] mod_power(logic [W-1:0] b, logic [W-1:0] e);
      logic [2*W-1:0] n;
      logic [2*W-1:0] sq;
      logic [2*W-1:0] acc;
      if (modulus == 0) begin
        return '0;
      end
      n = modulus;
      sq = b % n;
      acc = 1 % n;
      for (int i = 0; i < W; i++) begin
        if (e[i]) begin
          acc = (acc * sq) % n;
        end
        sq = (sq * sq) % n;
      end
      return acc[W-1:0];
    endfunction

    function void note_item(logic [W-1:0] b, logic [W-1:0] e);
      expected_q.push_back(mod_power(b, e));
    endfunction

    function void check_result(logic [W-1:0] actual);
      logic [W-1:0] want;
      if (expected_q.size() == 0) begin
        $error("power_result: nothing expected, got %h", actual);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (actual !== want) begin
        $error("power_result: expected %h, actual %h", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [W-1:0] in_base = '0;
  logic [W-1:0] in_exponent = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [W-1:0] out_power_result;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [AW-1:0] cfg_paddr = '0;
  logic [DW-1:0] cfg_pwdata = '0;
  logic [DW-1:0] cfg_prdata;
  logic cfg_pready;

  PowerScoreboard sb;
  bit no_idle = 1'b0;
  int unsigned idle_cycles = 0;

  modular_exponentiation dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_base(in_base),
    .in_exponent(in_exponent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_power_result(out_power_result),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 200);
  endfunction

  function logic [W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return sb.modulus - 1;
      2: return sb.modulus + $urandom_range(0, 3);
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Full-width exponents are slow, so a good share is kept short.
  function logic [W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      5, 6, 7: return $urandom_range(0, 255);
      8: return 1 << $urandom_range(0, W - 1);
      9: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return 1;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [W-1:0] b, logic [W-1:0] e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base <= b;
    in_exponent <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  // The last beat is noted at the edge that accepted it, so the count is
  // looked at only from the next edge on.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(int index, logic [DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AW'(index * REG_STRIDE);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (index == REG_MODULUS) begin
      sb.modulus = value[W-1:0];
    end
  endtask

  task automatic check_modulus_readback();
    logic [DW-1:0] got;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= AW'(REG_MODULUS * REG_STRIDE);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (got[W-1:0] !== sb.modulus) begin
      $error("modulus: expected %h, actual %h", sb.modulus, got[W-1:0]);
      sb.errors++;
    end
  endtask

  task automatic set_modulus(logic [W-1:0] value);
    apb_write(REG_MODULUS, value);
    check_modulus_readback();
  endtask

  // Every beat on either channel is handed to the scoreboard here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_item(in_base, in_exponent);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_power_result);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [W-1:0] m;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A modulus of one after reset turns everything into zero.
    check_modulus_readback();
    send_item('0, '0);
    send_item('1, '1);
    send_item(5, 3);
    drain();

    set_modulus('1);
    send_item('0, '0);
    send_item('0, 5);
    send_item('1, 7);
    send_item('1 - 1, 2);
    send_item('1 - 1, '1);
    send_item(2, 32);
    send_item(32'h075b_cd15, '1);
    drain();

    // A write past the register map must leave the modulus alone.
    apb_write(REG_UNUSED, 7);
    check_modulus_readback();
    send_item(3, 40);
    drain();

    set_modulus(2);
    send_item(7, 0);
    send_item(7, 1);
    send_item(6, 3);
    drain();

    set_modulus('0);
    send_item(5, 5);
    send_item('0, '0);
    drain();

    // Largest prime below 2**32: Fermat gives one.
    set_modulus(32'hffff_fffb);
    send_item(2, 32'hffff_fffa);
    send_item(32'h1234_5678, 32'h8000_0000);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: m = '1;
        1: m = 1;
        2: m = $urandom | 1;
        3: m = 3;
        4: m = $urandom_range(2, 65535);
        5: m = $urandom | 32'h8000_0000;
        6: m = $urandom;
        default: m = 32'hffff_fffb;
      endcase
      set_modulus(m);
      no_idle = (p % 4 == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(pick_base(), pick_exponent());
      end
      drain();
    end

    no_idle = 1'b0;
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/mexp_pkg.sv
rtl/modular_exponentiation.sv
test/testbench.sv
